[rtl/rom_ram_bank_mapper_mode_select_core_assert.svh]
// ----------------------------------------------------------------------------
// rom_ram_bank_mapper_mode_select_core_assert.svh
// assertion macros used by the bank mapper checker
// ----------------------------------------------------------------------------
`ifndef ROM_RAM_BANK_MAPPER_MODE_SELECT_CORE_ASSERT_SVH
`define ROM_RAM_BANK_MAPPER_MODE_SELECT_CORE_ASSERT_SVH

// clocked assertion, off while reset is high
`define RRBM_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// clocked assertion, also checked during reset
`define RRBM_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/rrbm_pkg.sv]
// ----------------------------------------------------------------------------
// rrbm_pkg
// types and constants of the rom/ram bank mapper
// ----------------------------------------------------------------------------
package rrbm_pkg;

   localparam int unsigned ROM_BANK_BYTES = 16384;
   localparam int unsigned RAM_BANK_BYTES = 8192;

   localparam int unsigned ADDR_W  = 15;
   localparam int unsigned DATA_W  = 8;
   localparam int unsigned INDEX_W = 21;
   localparam int unsigned ROM_OFS_W = $clog2(ROM_BANK_BYTES);

   // bus functions
   localparam logic [1:0] FUNC_ROM_READ  = 2'd0;
   localparam logic [1:0] FUNC_CTRL_WR   = 2'd1;
   localparam logic [1:0] FUNC_RAM_READ  = 2'd2;
   localparam logic [1:0] FUNC_RAM_WRITE = 2'd3;

   // result targets
   localparam logic [1:0] TARGET_NONE = 2'd0;
   localparam logic [1:0] TARGET_ROM  = 2'd1;
   localparam logic [1:0] TARGET_RAM  = 2'd2;

   // control register select, address bits 14..13
   localparam logic [1:0] SEL_RAM_ENABLE = 2'd0;
   localparam logic [1:0] SEL_ROM_LOW    = 2'd1;
   localparam logic [1:0] SEL_BANK_HIGH  = 2'd2;
   localparam logic [1:0] SEL_MODE       = 2'd3;

   localparam logic [3:0] RAM_ENABLE_KEY = 4'hA;

   typedef struct packed {
      logic       ram_enabled;
      logic [4:0] rom_bank_low;
      logic [1:0] rom_bank_high;
      logic [1:0] ram_bank;
      logic       ram_banking_mode;
   } bank_state_type;

   localparam bank_state_type BANK_STATE_RESET = '{
      ram_enabled:      1'b0,
      rom_bank_low:     5'd1,
      rom_bank_high:    2'd0,
      ram_bank:         2'd0,
      ram_banking_mode: 1'b0
   };

endpackage

[rtl/rom_ram_bank_mapper_mode_select_core.sv]
// ----------------------------------------------------------------------------
// rom_ram_bank_mapper_mode_select_core
// cartridge bank controller: control writes and banked rom/ram address forming
// response is registered: valid in the cycle after request acceptance
// throughput: 1 transaction per cycle unless stalled, one response register
// reset: synchronous, loads the bank registers with their reset values and
// clears the response valid
// ----------------------------------------------------------------------------
module rom_ram_bank_mapper_mode_select_core (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [1:0]                  req_func,
   input  logic [rrbm_pkg::ADDR_W-1:0] req_bus_address,
   input  logic [rrbm_pkg::DATA_W-1:0] req_write_byte,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [1:0]                  rsp_target,
   output logic [rrbm_pkg::INDEX_W-1:0] rsp_mem_index,
   output logic                        rsp_mem_write,
   output logic [rrbm_pkg::DATA_W-1:0] rsp_store_byte,
   output logic                        rsp_read_open
);
   import rrbm_pkg::*;

   bank_state_type       state_ff, state_in;
   logic                 valid_ff;
   logic [1:0]           target_ff, target_in;
   logic [INDEX_W-1:0]   index_ff, index_in;
   logic                 write_ff, write_in;
   logic [DATA_W-1:0]    byte_ff, byte_in;
   logic                 open_ff, open_in;
   logic                 req_fire;
   logic [6:0]           rom_bank;
   logic [6:0]           rom_bank_m1;
   logic [4:0]           low_val;

   assign req_stall = valid_ff & rsp_stall;
   assign req_fire  = req_valid & ~req_stall;

   always_comb begin
      state_in  = state_ff;
      target_in = TARGET_NONE;
      index_in  = '0;
      write_in  = 1'b0;
      byte_in   = '0;
      open_in   = 1'b0;
      rom_bank  = {state_ff.rom_bank_high, state_ff.rom_bank_low};
      if (rom_bank == 7'd0) begin
         rom_bank = 7'd1;
      end
      rom_bank_m1 = rom_bank - 7'd1;
      low_val     = req_write_byte[4:0];
      if (low_val == 5'd0) begin
         low_val = 5'd1;
      end
      unique case (req_func)
         FUNC_ROM_READ: begin
            target_in = TARGET_ROM;
            index_in  = {rom_bank_m1, {ROM_OFS_W{1'b0}}}
                        + INDEX_W'(req_bus_address);
         end
         FUNC_CTRL_WR: begin
            unique case (req_bus_address[14:13])
               SEL_RAM_ENABLE: begin
                  state_in.ram_enabled = (req_write_byte[3:0] == RAM_ENABLE_KEY);
               end
               SEL_ROM_LOW: begin
                  state_in.rom_bank_low = low_val;
               end
               SEL_BANK_HIGH: begin
                  if (state_ff.ram_banking_mode) begin
                     state_in.ram_bank = req_write_byte[1:0];
                  end else begin
                     state_in.rom_bank_high = req_write_byte[1:0];
                  end
               end
               SEL_MODE: begin
                  if (req_write_byte != '0) begin
                     state_in.ram_banking_mode = 1'b1;
                     state_in.rom_bank_high    = 2'd0;
                  end else begin
                     state_in.ram_banking_mode = 1'b0;
                     state_in.ram_bank         = 2'd0;
                  end
               end
               default: begin
                  state_in = state_ff;
               end
            endcase
         end
         FUNC_RAM_READ, FUNC_RAM_WRITE: begin
            if (state_ff.ram_enabled) begin
               target_in = TARGET_RAM;
               index_in  = INDEX_W'(state_ff.ram_bank) * INDEX_W'(RAM_BANK_BYTES)
                           + INDEX_W'(req_bus_address);
               if (req_func == FUNC_RAM_WRITE) begin
                  write_in = 1'b1;
                  byte_in  = req_write_byte;
               end
            end else if (req_func == FUNC_RAM_READ) begin
               open_in = 1'b1;
            end
         end
         default: begin
            target_in = TARGET_NONE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BANK_STATE_RESET;
         valid_ff <= 1'b0;
      end else begin
         if (req_fire) begin
            state_ff <= state_in;
            valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            valid_ff <= 1'b0;
         end
      end
   end

   // response payload
   always_ff @(posedge clock) begin
      if (req_fire) begin
         target_ff <= target_in;
         index_ff  <= index_in;
         write_ff  <= write_in;
         byte_ff   <= byte_in;
         open_ff   <= open_in;
      end
   end

   assign rsp_valid      = valid_ff;
   assign rsp_target     = target_ff;
   assign rsp_mem_index  = index_ff;
   assign rsp_mem_write  = write_ff;
   assign rsp_store_byte = byte_ff;
   assign rsp_read_open  = open_ff;

endmodule

[rtl/rrbm_checker.sv]
// ----------------------------------------------------------------------------
// rrbm_checker
// port level checks of the rom/ram bank mapper, bound to the top level
// ----------------------------------------------------------------------------
`include "rom_ram_bank_mapper_mode_select_core_assert.svh"

module rrbm_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_valid,
   input logic                         req_stall,
   input logic [1:0]                   req_func,
   input logic                         rsp_valid,
   input logic                         rsp_stall,
   input logic [1:0]                   rsp_target,
   input logic [rrbm_pkg::INDEX_W-1:0] rsp_mem_index,
   input logic                         rsp_mem_write,
   input logic [rrbm_pkg::DATA_W-1:0]  rsp_store_byte,
   input logic                         rsp_read_open
);
   import rrbm_pkg::*;

   logic                         rom_fire;
   logic                         not_ram;
   logic                         no_store;
   logic                         open_rsp;
   logic                         no_access;
   logic                         rsp_held;
   logic                         rom_rsp;
   logic [INDEX_W+DATA_W+3:0]    rsp_payload;

   assign rom_fire    = req_valid && !req_stall && (req_func == FUNC_ROM_READ);
   assign not_ram     = rsp_valid && (rsp_target != TARGET_RAM);
   assign no_store    = !rsp_mem_write && (rsp_store_byte == '0);
   assign open_rsp    = rsp_valid && rsp_read_open;
   assign no_access   = (rsp_target == TARGET_NONE) && (rsp_mem_index == '0)
                        && !rsp_mem_write;
   assign rsp_held    = rsp_valid && rsp_stall;
   assign rom_rsp     = rsp_valid && (rsp_target == TARGET_ROM);
   assign rsp_payload = {rsp_target, rsp_mem_index, rsp_mem_write, rsp_store_byte,
                         rsp_read_open};

   // a write only ever goes to ram
   `RRBM_ASSERT(a_write_ram_only, clock, reset, not_ram |-> no_store, "write without ram target")

   // open read carries no memory access
   `RRBM_ASSERT(a_open_no_access, clock, reset, open_rsp |-> no_access, "open read with access")

   // an accepted rom read shows up as a rom transaction next cycle
   `RRBM_ASSERT(a_rom_read_next, clock, reset, rom_fire |=> rom_rsp, "rom read transaction lost")

   // a stalled response holds
   `RRBM_ASSERT(a_rsp_hold, clock, reset, rsp_held |=> (rsp_valid && $stable(rsp_payload)), "stalled transaction changed")

endmodule

bind rom_ram_bank_mapper_mode_select_core rrbm_checker u_rrbm_checker (.*);

[test/rom_ram_bank_mapper_mode_select_core_test.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rom_ram_bank_mapper_mode_select_core_test
// Drives bus accesses into the bank mapper under random request and response
// stalls. A scoreboard keeps its own copy of the bank registers, predicts the
// translated rom/ram index of every accepted access and checks the responses
// in order.
// ----------------------------------------------------------------------------
module rom_ram_bank_mapper_mode_select_core_test;
   import rrbm_pkg::*;

   localparam int unsigned WATCHDOG_LIMIT = 2000;
   localparam int unsigned HOLD_CYCLES    = 150;
   localparam int unsigned RANDOM_ACCESSES = 1550;

   typedef struct packed {
      logic [1:0]         target;
      logic [INDEX_W-1:0] mem_index;
      logic               mem_write;
      logic [DATA_W-1:0]  store_byte;
      logic               read_open;
   } bank_result_type;

   class bank_access_scoreboard;
      bank_state_type  regs;
      bank_result_type expected_q[$];
      int unsigned     errors;

      function new();
         regs = BANK_STATE_RESET;
         errors = 0;
      endfunction

      function int unsigned pending();
         return expected_q.size();
      endfunction

      function void apply_control(logic [ADDR_W-1:0] addr, logic [DATA_W-1:0] data);
         logic [4:0] low;
         case (addr[14:13])
            SEL_RAM_ENABLE: begin
               regs.ram_enabled = (data[3:0] == RAM_ENABLE_KEY);
            end
            SEL_ROM_LOW: begin
               low = data[4:0];
               regs.rom_bank_low = (low == 5'd0) ? 5'd1 : low;
            end
            SEL_BANK_HIGH: begin
               if (regs.ram_banking_mode)
                  regs.ram_bank = data[1:0];
               else
                  regs.rom_bank_high = data[1:0];
            end
            default: begin
               if (data != '0) begin
                  regs.ram_banking_mode = 1'b1;
                  regs.rom_bank_high = 2'd0;
               end else begin
                  regs.ram_banking_mode = 1'b0;
                  regs.ram_bank = 2'd0;
               end
            end
         endcase
      endfunction

      function void note_access(logic [1:0] func, logic [ADDR_W-1:0] addr,
                                logic [DATA_W-1:0] data);
         bank_result_type res;
         int unsigned     bank;
         int unsigned     index;
         res = '0;
         if (func == FUNC_ROM_READ) begin
            bank = 32'({regs.rom_bank_high, regs.rom_bank_low});
            if (bank == 0)
               bank = 1;
            index = (bank - 1) * ROM_BANK_BYTES + 32'(addr);
            res.target = TARGET_ROM;
            res.mem_index = index[INDEX_W-1:0];
         end else if (func == FUNC_CTRL_WR) begin
            apply_control(addr, data);
         end else if (regs.ram_enabled) begin
            index = 32'(regs.ram_bank) * RAM_BANK_BYTES + 32'(addr);
            res.target = TARGET_RAM;
            res.mem_index = index[INDEX_W-1:0];
            if (func == FUNC_RAM_WRITE) begin
               res.mem_write = 1'b1;
               res.store_byte = data;
            end
         end else if (func == FUNC_RAM_READ) begin
            res.read_open = 1'b1;
         end
         expected_q.push_back(res);
      endfunction

      function void compare_field(string name, int unsigned exp, int unsigned act);
         if (exp != act) begin
            errors++;
            $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, exp, act);
         end
      endfunction

      function void check_result(bank_result_type act);
         bank_result_type exp;
         if (expected_q.size() == 0) begin
            errors++;
            $display("%0t: unexpected transaction, expected none actual %0h", $time, act);
            return;
         end
         exp = expected_q.pop_front();
         compare_field("target", 32'(exp.target), 32'(act.target));
         compare_field("mem_index", 32'(exp.mem_index), 32'(act.mem_index));
         compare_field("mem_write", 32'(exp.mem_write), 32'(act.mem_write));
         compare_field("store_byte", 32'(exp.store_byte), 32'(act.store_byte));
         compare_field("read_open", 32'(exp.read_open), 32'(act.read_open));
      endfunction
   endclass

   logic                clock;
   logic                reset;
   logic                req_valid;
   logic                req_stall;
   logic [1:0]          req_func;
   logic [ADDR_W-1:0]   req_bus_address;
   logic [DATA_W-1:0]   req_write_byte;
   logic                rsp_valid;
   logic                rsp_stall;
   logic [1:0]          rsp_target;
   logic [INDEX_W-1:0]  rsp_mem_index;
   logic                rsp_mem_write;
   logic [DATA_W-1:0]   rsp_store_byte;
   logic                rsp_read_open;

   bank_access_scoreboard sb = new();
   bit          req_idle_on = 1'b1;
   bit          rsp_idle_on = 1'b1;
   bit          hold_rsp_request = 1'b0;
   int unsigned idle_cycles = 0;

   rom_ram_bank_mapper_mode_select_core u_top (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_func        (req_func),
      .req_bus_address (req_bus_address),
      .req_write_byte  (req_write_byte),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_target      (rsp_target),
      .rsp_mem_index   (rsp_mem_index),
      .rsp_mem_write   (rsp_mem_write),
      .rsp_store_byte  (rsp_store_byte),
      .rsp_read_open   (rsp_read_open)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // transaction monitor and watchdog
   always @(posedge clock) begin
      if (reset) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (req_valid && !req_stall) begin
            sb.note_access(req_func, req_bus_address, req_write_byte);
            idle_cycles = 0;
         end
         if (rsp_valid && !rsp_stall) begin
            sb.check_result({rsp_target, rsp_mem_index, rsp_mem_write,
                             rsp_store_byte, rsp_read_open});
            idle_cycles = 0;
         end
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Some tests failed");
            $finish;
         end
      end
   end

   // response side
   initial begin
      int unsigned wait_cycles;
      rsp_stall <= 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         if (hold_rsp_request) begin
            wait_cycles = HOLD_CYCLES;
            hold_rsp_request = 1'b0;
         end else begin
            wait_cycles = rsp_idle_on ? $urandom_range(0, 13) : 0;
         end
         if (wait_cycles > 0) begin
            rsp_stall <= 1'b1;
            repeat (wait_cycles) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   task automatic send_access(input logic [1:0] func, input logic [ADDR_W-1:0] addr,
                              input logic [DATA_W-1:0] data);
      int unsigned gap;
      gap = req_idle_on ? $urandom_range(0, 13) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_func <= func;
      req_bus_address <= addr;
      req_write_byte <= data;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      do @(posedge clock); while (sb.pending() != 0);
   endtask

   initial begin
      int unsigned       pick;
      logic [1:0]        func;
      logic [ADDR_W-1:0] addr;
      logic [DATA_W-1:0] data;

      reset <= 1'b1;
      req_valid <= 1'b0;
      req_func <= FUNC_ROM_READ;
      req_bus_address <= '0;
      req_write_byte <= '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: reset banks, ram disabled, all control selects, index extremes
      send_access(FUNC_ROM_READ, 15'h0000, 8'h00);
      send_access(FUNC_ROM_READ, 15'h7FFF, 8'hFF);
      send_access(FUNC_RAM_READ, 15'h1234, 8'h00);
      send_access(FUNC_RAM_WRITE, 15'h0042, 8'h5A);
      send_access(FUNC_CTRL_WR, 15'h0000, 8'hFA);
      send_access(FUNC_RAM_WRITE, 15'h7FFF, 8'hFF);
      send_access(FUNC_RAM_READ, 15'h0000, 8'h00);
      send_access(FUNC_CTRL_WR, 15'h2000, 8'h00);
      send_access(FUNC_ROM_READ, 15'h0001, 8'h00);
      send_access(FUNC_CTRL_WR, 15'h3FFF, 8'hE0);
      send_access(FUNC_ROM_READ, 15'h4000, 8'h00);
      send_access(FUNC_CTRL_WR, 15'h2000, 8'hFF);
      send_access(FUNC_CTRL_WR, 15'h4000, 8'hFF);
      send_access(FUNC_ROM_READ, 15'h7FFF, 8'h00);
      send_access(FUNC_CTRL_WR, 15'h6000, 8'h01);
      send_access(FUNC_ROM_READ, 15'h0000, 8'h00);
      send_access(FUNC_CTRL_WR, 15'h5FFF, 8'h03);
      send_access(FUNC_RAM_WRITE, 15'h7FFF, 8'h00);
      send_access(FUNC_CTRL_WR, 15'h7FFF, 8'h00);
      send_access(FUNC_RAM_READ, 15'h1FFF, 8'h00);
      send_access(FUNC_CTRL_WR, 15'h1FFF, 8'h0B);
      send_access(FUNC_RAM_READ, 15'h7FFF, 8'hFF);
      send_access(FUNC_RAM_WRITE, 15'h7FFF, 8'hFF);
      send_access(FUNC_CTRL_WR, 15'h6000, 8'h80);

      for (int n = 0; n < RANDOM_ACCESSES; n++) begin
         if (n % 100 == 0) begin
            req_idle_on = ($urandom_range(0, 3) != 0);
            rsp_idle_on = ($urandom_range(0, 3) != 0);
         end
         // receiver holds off while the sender keeps pushing
         if (n == 400) begin
            hold_rsp_request = 1'b1;
            req_idle_on = 1'b0;
         end
         if (n == 800)
            drain_results();
         pick = $urandom_range(0, 99);
         addr = ADDR_W'($urandom_range(0, 32767));
         data = DATA_W'($urandom_range(0, 255));
         if (pick < 30) begin
            func = FUNC_CTRL_WR;
            if (addr[14:13] == SEL_RAM_ENABLE && $urandom_range(0, 2) != 0)
               data[3:0] = RAM_ENABLE_KEY;
            if (addr[14:13] == SEL_MODE && $urandom_range(0, 1) != 0)
               data = '0;
         end else if (pick < 55) begin
            func = FUNC_ROM_READ;
         end else if (pick < 78) begin
            func = FUNC_RAM_READ;
         end else begin
            func = FUNC_RAM_WRITE;
         end
         send_access(func, addr, data);
      end

      drain_results();
      repeat (10) @(posedge clock);
      if (sb.errors == 0 && sb.pending() == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule

[files.f]
+incdir+rtl
rtl/rrbm_pkg.sv
rtl/rom_ram_bank_mapper_mode_select_core.sv
rtl/rrbm_checker.sv
test/rom_ram_bank_mapper_mode_select_core_test.sv
